/* hw/rtl/prmm_pkg.sv */
// ============================================================================
// prmm_pkg: shared types and constants of the point range min/max block
// Coordinate width, tracker widths, register indexes and the square root step.
// ============================================================================
`default_nettype none

package prmm_pkg;

  // Coordinate width in bits (signed Q8.8 metres at 16).
  localparam int COORD_WIDTH = 16;
  localparam int IN_DATA_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int EXT_W       = (SUM_W > 33) ? SUM_W : 33;

  localparam int SQ_W    = 32;
  localparam int RANGE_W = 16;
  localparam int CFG_IDX_W = 8;

  localparam logic [SQ_W-1:0]    SQ_ALL_ONES      = '1;
  localparam logic [RANGE_W-1:0] FAR_LIMIT_RESET  = 16'd3840;
  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RESET = 16'd3840;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAR_LIMIT  = 8'd0,
    REG_NEAR_LIMIT = 8'd1
  } prmm_reg_idx_t;

  // Tracker contents of one finished cloud.
  typedef struct packed {
    logic [SQ_W-1:0] min_sq;
    logic [SQ_W-1:0] max_sq;
  } prmm_pair_t;

  // Queue read side as seen by the back end.
  typedef struct packed {
    logic       valid;
    prmm_pair_t pair;
  } prmm_q_out_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } prmm_sqrt_t;

  // Magnitude of a two's complement coordinate; the most negative value
  // maps onto its unsigned magnitude.
  function automatic logic [COORD_WIDTH-1:0] coord_mag(input logic [COORD_WIDTH-1:0] v);
    logic [COORD_WIDTH-1:0] m;
    m = v[COORD_WIDTH-1] ? (~v + COORD_WIDTH'(1)) : v;
    return m;
  endfunction

  // One digit of the restoring integer square root.
  function automatic prmm_sqrt_t sqrt_step(input prmm_sqrt_t s, input logic [SQ_W-1:0] bit_v);
    logic [SQ_W:0] trial;
    prmm_sqrt_t    r;
    trial = {1'b0, s.root} + {1'b0, bit_v};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[SQ_W-1:0];
      r.root = (s.root >> 1) + bit_v;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/point_range_min_max.sv */
// ============================================================================
// point_range_min_max: nearest and farthest point distance of a point cloud
// Tracks min/max squared distance per cloud and reports clamped Q8.8 ranges.
// ============================================================================
//
//  Channel   Direction  Transaction content
//  -------   ---------  ---------------------------------------------------
//  in_       input      one point: x, y, z in tdata; tlast marks cloud end
//  out_      output     one result per cloud: near_range, far_range
//  cfg_      input      one register write: index and 16-bit value
//
//  Points are taken one per cycle; squaring and min/max tracking are pipelined
//  over two register stages. The last point of a cloud hands the trackers to a
//  two-entry queue. The square root unit takes the tracker pair from the queue,
//  then works out one digit of both roots per step; the last step, which waits
//  while the result register is still full, also loads the result register.
//  Point intake stalls only when the queue is full with two clouds waiting.
//  Reset (rst_n, synchronous, active low) restores both limits to 15 m and
//  clears the trackers; there is no clearing pass.
//
`default_nettype none

module point_range_min_max
  import prmm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Point stream.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: point_x [15:0], point_y [31:16], point_z [47:32]
  input  wire logic [IN_DATA_W-1:0]   in_tdata,
  input  wire logic                   in_tlast,
  // Result stream.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: near_range [15:0], far_range [31:16]
  output logic [2*RANGE_W-1:0]        out_tdata,
  // Register writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [RANGE_W-1:0]     cfg_data
);

  // Configuration registers. Writes to an unknown index are dropped.
  logic [RANGE_W-1:0] far_limit_r, near_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_limit_r  <= FAR_LIMIT_RESET;
      near_limit_r <= NEAR_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FAR_LIMIT) begin
        far_limit_r <= cfg_data;
      end
      if (cfg_index == REG_NEAR_LIMIT) begin
        near_limit_r <= cfg_data;
      end
    end
  end

  // Front end: squares and tracks; pushes the tracker pair at cloud end.
  logic        push;
  prmm_pair_t  push_pair;
  logic        q_ready;
  logic        pop;
  prmm_q_out_t q_out;

  prmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_pair (push_pair),
    .q_ready   (q_ready)
  );

  // The queue decouples point intake from the multi-cycle root unit.
  prmm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_out     (q_out)
  );

  // Back end: square roots, clamping against the limits, output register.
  prmm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_out      (q_out),
    .pop        (pop),
    .far_limit  (far_limit_r),
    .near_limit (near_limit_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/prmm_front.sv */
// ============================================================================
// prmm_front: point intake and squared distance tracking
// Squares the coordinates, sums them and keeps the running min and max.
// ============================================================================
`default_nettype none

module prmm_front
  import prmm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 in_tlast,
  output logic                      push,
  output prmm_pair_t                push_pair,
  input  wire logic                 q_ready
);

  logic              p_vld_r;
  logic              p_last_r;
  logic [PROD_W-1:0] sq_x_r, sq_y_r, sq_z_r;
  logic [SQ_W-1:0]   min_r, max_r;

  logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;
  logic [SUM_W-1:0]       sum;
  logic [SQ_W-1:0]        sq;
  logic [SQ_W-1:0]        new_min, new_max;
  logic                   consume;
  logic                   accept;

  assign mag_x = coord_mag(in_tdata[COORD_WIDTH-1:0]);
  assign mag_y = coord_mag(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign mag_z = coord_mag(in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);

  always_comb begin
    sum = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
    if (EXT_W'(sum) > EXT_W'(SQ_ALL_ONES)) begin
      sq = SQ_ALL_ONES;
    end else begin
      sq = SQ_W'(sum);
    end
    new_min = (sq < min_r) ? sq : min_r;
    new_max = (sq > max_r) ? sq : max_r;
  end

  assign consume   = p_vld_r && (!p_last_r || q_ready);
  assign in_tready = !p_vld_r || consume;
  assign accept    = in_tvalid && in_tready;
  assign push      = consume && p_last_r;
  assign push_pair = '{min_sq: new_min, max_sq: new_max};

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_x_r   <= PROD_W'(mag_x) * PROD_W'(mag_x);
      sq_y_r   <= PROD_W'(mag_y) * PROD_W'(mag_y);
      sq_z_r   <= PROD_W'(mag_z) * PROD_W'(mag_z);
      p_last_r <= in_tlast;
    end
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      min_r   <= SQ_ALL_ONES;
      max_r   <= '0;
    end else begin
      if (accept) begin
        p_vld_r <= 1'b1;
      end else if (consume) begin
        p_vld_r <= 1'b0;
      end
      if (consume) begin
        if (p_last_r) begin
          min_r <= SQ_ALL_ONES;
          max_r <= '0;
        end else begin
          min_r <= new_min;
          max_r <= new_max;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/prmm_queue.sv */
// ============================================================================
// prmm_queue: two-entry queue of finished tracker pairs
// Lets point intake carry on while the square roots of a cloud are running.
// ============================================================================
`default_nettype none

module prmm_queue
  import prmm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire prmm_pair_t  push_pair,
  output logic             q_ready,
  input  wire logic        pop,
  output prmm_q_out_t      q_out
);

  prmm_pair_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign q_ready     = (cnt_r != 2'd2);
  assign do_push     = push && q_ready;
  assign do_pop      = pop && (cnt_r != 2'd0);
  assign q_out.valid = (cnt_r != 2'd0);
  assign q_out.pair  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pair;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/prmm_back.sv */
// ============================================================================
// prmm_back: square roots, clamping and result register
// Runs both roots one digit per cycle, last when output frees; clamps, holds.
// ============================================================================
`default_nettype none

module prmm_back
  import prmm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prmm_q_out_t        q_out,
  output logic                    pop,
  input  wire logic [RANGE_W-1:0] far_limit,
  input  wire logic [RANGE_W-1:0] near_limit,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [2*RANGE_W-1:0]    out_tdata
);

  typedef enum logic {
    ST_IDLE,
    ST_ROOT
  } state_t;

  state_t          state_r;
  logic [SQ_W-1:0] bit_r;
  prmm_sqrt_t      near_r, far_r;
  logic            out_vld_r;
  logic [RANGE_W-1:0] out_near_r, out_far_r;

  prmm_sqrt_t      near_nxt, far_nxt;
  logic            out_free;
  logic            finish;
  logic            step;
  logic [RANGE_W-1:0] near_clamp, far_clamp;

  assign out_free = !out_vld_r || out_tready;
  assign pop      = (state_r == ST_IDLE) && q_out.valid;
  assign finish   = (state_r == ST_ROOT) && bit_r[0] && out_free;
  assign step     = (state_r == ST_ROOT) && (!bit_r[0] || out_free);

  always_comb begin
    near_nxt = sqrt_step(near_r, bit_r);
    far_nxt  = sqrt_step(far_r, bit_r);
    near_clamp = (near_nxt.root > SQ_W'(near_limit)) ? near_limit : near_nxt.root[RANGE_W-1:0];
    far_clamp  = (far_nxt.root > SQ_W'(far_limit)) ? far_limit : far_nxt.root[RANGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      near_r <= '{rem: q_out.pair.min_sq, root: '0};
      far_r  <= '{rem: q_out.pair.max_sq, root: '0};
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (step) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
      bit_r  <= bit_r >> 2;
    end
    if (finish) begin
      out_near_r <= near_clamp;
      out_far_r  <= far_clamp;
    end
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (finish) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_far_r, out_near_r};

  // The digit marker is a single bit for the whole root computation.
  a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> $onehot(bit_r))
    else $error("square root digit marker is not one-hot");

  // A pop from the queue always starts a root computation.
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_ROOT))
    else $error("queue pop did not start a root computation");

  // The root of a 32-bit value fits in 16 bits when it completes.
  a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (near_nxt.root[SQ_W-1:RANGE_W] == '0 && far_nxt.root[SQ_W-1:RANGE_W] == '0))
    else $error("square root result exceeds 16 bits");

endmodule

`default_nettype wire
